### hw/rtl/vn_pkg.sv
package vn_pkg;

    // component width of the input fields
    localparam int CW = 32;
    // squared-length sum: three squares of at most 2^(2CW-2) fit in 2CW bits
    localparam int SW = 2 * CW;
    // root of the sum fits in CW bits
    localparam int RW = CW;
    // unit fraction bits, and dividend width for mag * 2^30 + root / 2
    localparam int FB = 30;
    localparam int NW = CW + FB + 1;
    // quotient bits: 30 fraction bits plus the saturation bit
    localparam int QW = FB + 1;
    localparam int OW = 32;

    typedef struct packed {
        logic [2:0][CW-1:0] mag;
        logic [2:0]         neg;
        logic               zero;
    } side_t;

endpackage

### hw/rtl/vec3_normalize.sv
// vec3_normalize: unit vector and length of a 3D fixed-point vector.
//
// Input channel (s_): x, y, z as signed Q16.16, one transaction per vector.
// Output channel (m_): x_unit, y_unit, z_unit as signed Q2.30 (rounded to
// nearest, saturated to +/-1.0), vec_length as unsigned Q16.16 (floor of the
// square root), and zero_length for the all-zero vector, which returns zeros.
//
// The pipeline has 3 front stages (magnitude, squares, sum), 32 square-root
// stages (one root bit each), one dividend stage, 31 divider stages (one
// quotient bit each) and the output register. Throughput is one vector per
// cycle while the receiver does not stall.
//
// All stages advance together whenever the output register is empty or being
// taken; when the receiver stalls the whole pipe holds, s_ready falls and no
// transaction is lost or repeated. Synchronous reset (aresetn low) clears all
// valid bits; data registers are not reset.
module vec3_normalize (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [vn_pkg::CW-1:0]  s_x_in,
    input  logic signed [vn_pkg::CW-1:0]  s_y_in,
    input  logic signed [vn_pkg::CW-1:0]  s_z_in,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [vn_pkg::OW-1:0]  m_x_unit,
    output logic signed [vn_pkg::OW-1:0]  m_y_unit,
    output logic signed [vn_pkg::OW-1:0]  m_z_unit,
    output logic [vn_pkg::OW-1:0]         m_vec_length,
    output logic                          m_zero_length
);
    import vn_pkg::*;

    localparam int LW = (RW > OW) ? RW : OW;

    logic                en;
    logic                fr_valid;
    logic [SW-1:0]       fr_sum;
    side_t               fr_side;
    logic                sq_valid;
    logic [RW-1:0]       sq_root;
    side_t               sq_side;
    logic                dv_valid;
    logic [2:0][QW-1:0]  dv_quot;
    logic [RW-1:0]       dv_root;
    side_t               dv_side;
    logic [2:0][OW-1:0]  unit_next;
    logic [LW-1:0]       len_wide;
    logic [OW-1:0]       len_next;

    logic                out_valid_reg;
    logic [2:0][OW-1:0]  unit_reg;
    logic [OW-1:0]       len_reg;
    logic                zero_reg;

    // global advance: the whole pipe moves unless the output is held
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    vn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_comp   ({s_z_in, s_y_in, s_x_in}),
        .out_valid (fr_valid),
        .out_sum   (fr_sum),
        .out_side  (fr_side)
    );

    vn_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_sum    (fr_sum),
        .in_side   (fr_side),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    vn_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_quot  (dv_quot),
        .out_root  (dv_root),
        .out_side  (dv_side)
    );

    // saturate, restore sign, squash the zero vector
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            logic [OW-1:0] mag;
            mag = dv_quot[j][QW-1] ? (OW'(1) << FB) : OW'(dv_quot[j]);
            if (dv_side.zero) begin
                unit_next[j] = '0;
            end else begin
                unit_next[j] = dv_side.neg[j] ? (~mag + OW'(1)) : mag;
            end
        end
        len_wide = LW'(dv_root);
        if (dv_side.zero) begin
            len_next = '0;
        end else if (len_wide > LW'({OW{1'b1}})) begin
            len_next = '1;
        end else begin
            len_next = len_wide[OW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            unit_reg <= unit_next;
            len_reg  <= len_next;
            zero_reg <= dv_side.zero;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_x_unit      = unit_reg[0];
    assign m_y_unit      = unit_reg[1];
    assign m_z_unit      = unit_reg[2];
    assign m_vec_length  = len_reg;
    assign m_zero_length = zero_reg;

    // zero vector gives all-zero outputs
    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_length |-> (m_vec_length == '0) && (m_x_unit == '0)
            && (m_y_unit == '0) && (m_z_unit == '0))
        else $error("zero vector with nonzero outputs");

    // a nonzero vector has a nonzero truncated root
    a_len_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_zero_length |-> m_vec_length != '0)
        else $error("nonzero vector with zero length");

    // unit components stay within +/-1.0
    a_unit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_x_unit <= 32'sh4000_0000) && (m_x_unit >= -32'sh4000_0000)
            && (m_y_unit <= 32'sh4000_0000) && (m_y_unit >= -32'sh4000_0000)
            && (m_z_unit <= 32'sh4000_0000) && (m_z_unit >= -32'sh4000_0000))
        else $error("unit component out of range");

endmodule

### hw/rtl/vn_front.sv
module vn_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [2:0][vn_pkg::CW-1:0]  in_comp,
    output logic                        out_valid,
    output logic [vn_pkg::SW-1:0]       out_sum,
    output vn_pkg::side_t               out_side
);
    import vn_pkg::*;

    logic [2:0][CW-1:0] mag_reg;
    logic [2:0]         neg_reg;
    logic               v1_reg;
    logic [2:0][SW-1:0] sq_reg;
    logic [2:0][CW-1:0] mag2_reg;
    logic [2:0]         neg2_reg;
    logic               v2_reg;
    logic [SW-1:0]      sum_reg;
    side_t              side_reg;
    logic               v3_reg;
    logic [SW-1:0]      sum_next;

    assign sum_next = sq_reg[0] + sq_reg[1] + sq_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                neg_reg[k] <= in_comp[k][CW-1];
                mag_reg[k] <= in_comp[k][CW-1] ? (~in_comp[k] + CW'(1)) : in_comp[k];
                sq_reg[k]  <= SW'(mag_reg[k]) * SW'(mag_reg[k]);
            end
            mag2_reg      <= mag_reg;
            neg2_reg      <= neg_reg;
            sum_reg       <= sum_next;
            side_reg.mag  <= mag2_reg;
            side_reg.neg  <= neg2_reg;
            side_reg.zero <= (sum_next == '0);
        end
    end

    assign out_valid = v3_reg;
    assign out_sum   = sum_reg;
    assign out_side  = side_reg;

endmodule

### hw/rtl/vn_sqrt.sv
module vn_sqrt (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [vn_pkg::SW-1:0]   in_sum,
    input  vn_pkg::side_t           in_side,
    output logic                    out_valid,
    output logic [vn_pkg::RW-1:0]   out_root,
    output vn_pkg::side_t           out_side
);
    import vn_pkg::*;

    // one root bit per stage, MSB first; remainder holds sum - root^2
    logic [SW-1:0] rem_reg  [0:RW];
    logic [RW-1:0] root_reg [0:RW];
    side_t         side_reg [0:RW];
    logic          v_reg    [0:RW];

    assign rem_reg[0]  = in_sum;
    assign root_reg[0] = '0;
    assign side_reg[0] = in_side;
    assign v_reg[0]    = in_valid;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam int B = RW - 1 - k;
        logic [SW-1:0] trial;
        assign trial = (SW'(root_reg[k]) << (B + 1)) | (SW'(1) << (2 * B));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k+1] <= side_reg[k];
                if (rem_reg[k] >= trial) begin
                    rem_reg[k+1]  <= rem_reg[k] - trial;
                    root_reg[k+1] <= root_reg[k] | (RW'(1) << B);
                end else begin
                    rem_reg[k+1]  <= rem_reg[k];
                    root_reg[k+1] <= root_reg[k];
                end
            end
        end
    end

    assign out_valid = v_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_side  = side_reg[RW];

endmodule

### hw/rtl/vn_div.sv
module vn_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [vn_pkg::RW-1:0]       in_root,
    input  vn_pkg::side_t               in_side,
    output logic                        out_valid,
    output logic [2:0][vn_pkg::QW-1:0]  out_quot,
    output logic [vn_pkg::RW-1:0]       out_root,
    output vn_pkg::side_t               out_side
);
    import vn_pkg::*;

    // stage 0 forms the rounded dividend, then one quotient bit per stage
    logic [2:0][NW-1:0] rem_reg  [0:QW];
    logic [2:0][QW-1:0] q_reg    [0:QW];
    logic [RW-1:0]      root_reg [0:QW];
    side_t              side_reg [0:QW];
    logic               v_reg    [0:QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < 3; j++) begin
                rem_reg[0][j] <= (NW'(in_side.mag[j]) << FB) + NW'(in_root >> 1);
            end
            q_reg[0]    <= '0;
            root_reg[0] <= in_root;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;
        logic [NW-1:0] dsh;
        assign dsh = NW'(root_reg[k]) << B;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k+1] <= 1'b0;
            end else if (en) begin
                v_reg[k+1] <= v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k+1] <= root_reg[k];
                side_reg[k+1] <= side_reg[k];
                for (int j = 0; j < 3; j++) begin
                    if (rem_reg[k][j] >= dsh) begin
                        rem_reg[k+1][j] <= rem_reg[k][j] - dsh;
                        q_reg[k+1][j]   <= q_reg[k][j] | (QW'(1) << B);
                    end else begin
                        rem_reg[k+1][j] <= rem_reg[k][j];
                        q_reg[k+1][j]   <= q_reg[k][j];
                    end
                end
            end
        end
    end

    assign out_valid = v_reg[QW];
    assign out_quot  = q_reg[QW];
    assign out_root  = root_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

### tb/tb_vec3_normalize.sv
`timescale 1ns / 100ps

// Checks vec3_normalize against its own predictor: length as floor of the
// square root of the exact sum of squares, unit components rounded to nearest
// (ties away from zero) and saturated to +/-1.0, zero vector flagged.
module tb_vec3_normalize;

    import vn_pkg::*;

    localparam int PIPE_DEPTH   = 68;
    localparam int RANDOM_ITEMS = 540;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } vec_t;

    typedef struct {
        logic signed [OW-1:0] xu;
        logic signed [OW-1:0] yu;
        logic signed [OW-1:0] zu;
        logic [OW-1:0]        len;
        logic                 zero;
    } unit_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [CW-1:0] s_x_in = '0;
    logic signed [CW-1:0] s_y_in = '0;
    logic signed [CW-1:0] s_z_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OW-1:0] m_x_unit, m_y_unit, m_z_unit;
    logic [OW-1:0] m_vec_length;
    logic m_zero_length;

    vec3_normalize u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_x_in(s_x_in), .s_y_in(s_y_in), .s_z_in(s_z_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_x_unit(m_x_unit), .m_y_unit(m_y_unit), .m_z_unit(m_z_unit),
        .m_vec_length(m_vec_length), .m_zero_length(m_zero_length)
    );

    always #5 aclk = ~aclk;

    vec_t  pending_vecs[$];
    unit_t expected_units[$];
    int    mismatches = 0;
    longint cycles = 0;

    // idling mode: 0 sender 17%/receiver 86%, 1 swapped, 2 none
    int  idle_mode = 0;
    bit  rx_hold = 1'b0;    // long receiver hold-off
    bit  tx_pause = 1'b0;   // sender stops offering

    // Magnitude of a component; the most negative value keeps 2^(CW-1).
    function automatic logic [CW-1:0] comp_mag(logic signed [CW-1:0] c);
        return c[CW-1] ? (~c + 1'b1) : c;
    endfunction

    // floor(sqrt(s)), bit by bit
    function automatic logic [CW-1:0] isqrt(logic [SW-1:0] s);
        logic [CW-1:0] r;
        logic [CW-1:0] t;
        r = '0;
        for (int b = CW - 1; b >= 0; b--) begin
            t = r | (CW'(1) << b);
            if ({{CW{1'b0}}, t} * {{CW{1'b0}}, t} <= s)
                r = t;
        end
        return r;
    endfunction

    // round(mag * 2^30 / len), saturated to 2^30
    function automatic logic [OW-1:0] unit_mag(logic [CW-1:0] mag, logic [CW-1:0] len);
        logic [127:0] num;
        logic [127:0] q;
        num = ({96'd0, mag} << FB) + {97'd0, len[CW-1:1]};
        q = num / {96'd0, len};
        if (q >= (128'd1 << FB))
            return OW'(1) << FB;
        return q[OW-1:0];
    endfunction

    function automatic unit_t normalise(vec_t v);
        unit_t u;
        logic [CW-1:0] mx, my, mz, len;
        logic [SW-1:0] sum;
        mx = comp_mag(v.x);
        my = comp_mag(v.y);
        mz = comp_mag(v.z);
        sum = {{CW{1'b0}}, mx} * {{CW{1'b0}}, mx} + {{CW{1'b0}}, my} * {{CW{1'b0}}, my}
            + {{CW{1'b0}}, mz} * {{CW{1'b0}}, mz};
        u = '{default: '0};
        if (sum == '0) begin
            u.zero = 1'b1;
            return u;
        end
        len = isqrt(sum);
        u.xu = v.x[CW-1] ? -unit_mag(mx, len) : unit_mag(mx, len);
        u.yu = v.y[CW-1] ? -unit_mag(my, len) : unit_mag(my, len);
        u.zu = v.z[CW-1] ? -unit_mag(mz, len) : unit_mag(mz, len);
        u.len = len;
        return u;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on %s: got %h want %h", field, got, want);
        mismatches++;
    endtask

    // Driver: one transaction per handshake, payload held until taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_vecs.size() > 0 && !tx_pause
                    && !(idle_mode == 0 && $urandom_range(99) < 17)
                    && !(idle_mode == 1 && $urandom_range(99) < 86)) begin
                vec_t v;
                v = pending_vecs.pop_front();
                s_x_in  <= v.x;
                s_y_in  <= v.y;
                s_z_in  <= v.z;
                s_valid <= 1'b1;
                expected_units.push_back(normalise(v));
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver ready with random stalls.
    always @(posedge aclk) begin
        if (rx_hold)
            m_ready <= 1'b0;
        else if (idle_mode == 0)
            m_ready <= $urandom_range(99) >= 86;
        else if (idle_mode == 1)
            m_ready <= $urandom_range(99) >= 17;
        else
            m_ready <= 1'b1;
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (expected_units.size() == 0) begin
                report_mismatch("unexpected transaction", 64'd1, 64'd0);
            end else begin
                unit_t e;
                e = expected_units.pop_front();
                if (m_x_unit !== e.xu) report_mismatch("x_unit", m_x_unit, e.xu);
                if (m_y_unit !== e.yu) report_mismatch("y_unit", m_y_unit, e.yu);
                if (m_z_unit !== e.zu) report_mismatch("z_unit", m_z_unit, e.zu);
                if (m_vec_length !== e.len)
                    report_mismatch("vec_length", m_vec_length, e.len);
                if (m_zero_length !== e.zero)
                    report_mismatch("zero_length", m_zero_length, e.zero);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom_range(255) - 128;                  // tiny
            1: return $signed($urandom) >>> $urandom_range(31);  // spread of scales
            2: return $urandom_range(1) ? 32'sh7FFFFFFF : 32'sh80000000;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_vec(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                             logic signed [CW-1:0] z);
        vec_t v;
        v.x = x;
        v.y = y;
        v.z = z;
        pending_vecs.push_back(v);
    endtask

    task automatic drain();
        while (pending_vecs.size() > 0 || s_valid || expected_units.size() > 0)
            @(posedge aclk);
    endtask

    initial begin
        int hold;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero vector, extremes, axes, tiny and saturating cases
        queue_vec(0, 0, 0);
        queue_vec(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        queue_vec(32'sh80000000, 32'sh80000000, 32'sh80000000);
        queue_vec(32'sh80000000, 0, 0);
        queue_vec(0, 32'sh7FFFFFFF, 0);
        queue_vec(0, 0, -1);
        queue_vec(1, 0, 0);
        queue_vec(1, 1, 1);
        queue_vec(-1, 1, -1);
        queue_vec(32'sh00010000, 0, 0);
        queue_vec(0, -32'sh00010000, 0);
        queue_vec(3, 4, 0);
        queue_vec(32'sh00030000, 32'sh00040000, 32'sh000C0000);
        queue_vec(32'shFFFFFFFF, 32'sh00000002, 32'sh00000002);
        queue_vec(32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F);
        queue_vec(32'sh80000000, 32'sh7FFFFFFF, 1);
        queue_vec(0, 0, 0);
        drain();

        // receiver holds off while the sender keeps offering: pipe fills
        idle_mode = 2;
        rx_hold = 1'b1;
        for (int i = 0; i < 100; i++)
            queue_vec(rand_comp(), rand_comp(), rand_comp());
        hold = 0;
        while (hold < 200) begin
            @(posedge aclk);
            hold++;
        end
        rx_hold = 1'b0;
        drain();

        for (int mode = 0; mode < 3; mode++) begin
            idle_mode = mode;
            for (int i = 0; i < RANDOM_ITEMS / 3; i++) begin
                if ($urandom_range(19) == 0)
                    queue_vec(0, 0, 0);
                else
                    queue_vec(rand_comp(), rand_comp(), rand_comp());
            end
            // once half of the mode's items are sent, the sender pauses until every result has come back
            while (pending_vecs.size() > RANDOM_ITEMS / 6)
                @(posedge aclk);
            tx_pause = 1'b1;
            while (s_valid || expected_units.size() > 0)
                @(posedge aclk);
            tx_pause = 1'b0;
            drain();
        end

        repeat (PIPE_DEPTH + 10) @(posedge aclk);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/vn_pkg.sv
hw/rtl/vn_front.sv
hw/rtl/vn_sqrt.sv
hw/rtl/vn_div.sv
hw/rtl/vec3_normalize.sv
tb/tb_vec3_normalize.sv
